[rtl/sfct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfct_pkg: shared types and constants of the sphere/frustum cull test
// Register indexes and widths.
// ----------------------------------------------------------------------------
package sfct_pkg;
   localparam int NUM_REGS  = 8;
   localparam int NUM_PLANES = 6;
   localparam int ELEM_W    = 32;
   localparam int NORM_W    = 33;   // sum of two elements
   localparam int DOT_W     = 68;   // three 65-bit products plus offset
   localparam int LEN2_W    = 68;
   localparam int IDX_W     = 3;

   typedef logic [IDX_W-1:0] reg_idx_type;
   localparam reg_idx_type REG_E01   = 3'd0;
   localparam reg_idx_type REG_E23   = 3'd1;
   localparam reg_idx_type REG_E45   = 3'd2;
   localparam reg_idx_type REG_E67   = 3'd3;
   localparam reg_idx_type REG_E89   = 3'd4;
   localparam reg_idx_type REG_E1011 = 3'd5;
   localparam reg_idx_type REG_E1213 = 3'd6;
   localparam reg_idx_type REG_E1415 = 3'd7;
endpackage
`default_nettype wire

[rtl/sfct_plane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfct_plane: one plane test
// Five-stage pipeline: products, sums, partial squares, partial sums, compare.
// Advances on en.
// ----------------------------------------------------------------------------
module sfct_plane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic signed [sfct_pkg::NORM_W-1:0] n0,
   input  wire logic signed [sfct_pkg::NORM_W-1:0] n1,
   input  wire logic signed [sfct_pkg::NORM_W-1:0] n2,
   input  wire logic signed [sfct_pkg::NORM_W-1:0] dofs,
   input  wire logic signed [31:0]              cx,
   input  wire logic signed [31:0]              cy,
   input  wire logic signed [31:0]              cz,
   input  wire logic        [30:0]              rad,
   output logic                                 pass
);
   localparam int DW = sfct_pkg::DOT_W;
   localparam int LW = sfct_pkg::LEN2_W;
   localparam int HW = DW / 2;
   localparam int SW = 2 * DW + 1;
   localparam int RW = 62 + LW;
   // |n|^2 * 10^12 < 2^(2F)  <=>  |n|^2 <= floor((2^(2F)-1)/10^12)
   localparam longint unsigned THRESH =
      ((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000;

   // stage 1: center products, normal squares, radius square
   logic signed [65:0] p0_ff, p1_ff, p2_ff;
   logic signed [DW-1:0] d1_ff;
   logic [65:0] q0_ff, q1_ff, q2_ff;
   logic [61:0] r2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= 66'(n0) * 66'(cx);
         p1_ff <= 66'(n1) * 66'(cy);
         p2_ff <= 66'(n2) * 66'(cz);
         d1_ff <= DW'(dofs) <<< FRAC_BITS;
         q0_ff <= unsigned'(66'(n0) * 66'(n0));
         q1_ff <= unsigned'(66'(n1) * 66'(n1));
         q2_ff <= unsigned'(66'(n2) * 66'(n2));
         r2_ff <= 62'(rad) * 62'(rad);
      end
   end

   // stage 2: distance and length sums
   logic signed [DW-1:0] sdist_ff;
   logic [LW-1:0] len2_ff;
   logic [61:0] r2b_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sdist_ff <= DW'(p0_ff) + DW'(p1_ff) + DW'(p2_ff) + d1_ff;
         len2_ff  <= LW'(q0_ff) + LW'(q1_ff) + LW'(q2_ff);
         r2b_ff   <= r2_ff;
      end
   end

   // stage 3: split the squares into narrow partial products
   logic signed [HW-1:0] dh;
   logic        [HW-1:0] dl;
   logic        [30:0]   r2h, r2l;
   logic        [LW-HW-1:0] lnh;
   logic        [HW-1:0] lnl;
   assign dh  = sdist_ff[DW-1:HW];
   assign dl  = sdist_ff[HW-1:0];
   assign r2h = r2b_ff[61:31];
   assign r2l = r2b_ff[30:0];
   assign lnh = len2_ff[LW-1:HW];
   assign lnl = len2_ff[HW-1:0];

   logic signed [2*HW-1:0] hh_ff;
   logic signed [2*HW:0]   hl_ff;
   logic        [2*HW-1:0] ll_ff;
   logic        [64:0]     rhh_ff, rhl_ff, rlh_ff, rll_ff;
   logic                   ok3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff  <= (2*HW)'(dh) * (2*HW)'(dh);
         hl_ff  <= (2*HW+1)'(dh) * (2*HW+1)'($signed({1'b0, dl}));
         ll_ff  <= (2*HW)'(dl) * (2*HW)'(dl);
         rhh_ff <= 65'(r2h) * 65'(lnh);
         rhl_ff <= 65'(r2h) * 65'(lnl);
         rlh_ff <= 65'(r2l) * 65'(lnh);
         rll_ff <= 65'(r2l) * 65'(lnl);
         ok3_ff <= (len2_ff <= LW'(THRESH)) || !sdist_ff[DW-1];
      end
   end

   // stage 4: assemble the squared shortfall and the scaled radius square
   logic [SW-1:0] lhs_ff;
   logic [RW-1:0] rhs_ff;
   logic          ok4_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         lhs_ff <= (SW'(hh_ff) << (2*HW)) + (SW'(hl_ff) << (HW+1)) + SW'(ll_ff);
         rhs_ff <= (RW'(rhh_ff) << (31+HW)) + (RW'(rhl_ff) << 31)
                 + (RW'(rlh_ff) << HW) + RW'(rll_ff);
         ok4_ff <= ok3_ff;
      end
   end

   // stage 5: final compare
   always_ff @(posedge clock) begin
      if (en) pass <= ok4_ff || (lhs_ff <= SW'(rhs_ff));
   end
endmodule
`default_nettype wire

[rtl/sphere_frustum_cull_test.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_frustum_cull_test: bounding sphere against view frustum
// Six plane tests in parallel against a configured view-projection matrix.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  req     | valid / stall    | sphere_x, sphere_y, sphere_z, sphere_radius
//  rsp     | valid / stall    | visible
//  csr     | valid / ready    | index, wdata (64 bits)
// One sphere per cycle while rsp is not stalled; the stages are the normal
// build here, then the plane pipeline (products, sums, partial squares,
// partial sums, compare).
// A rsp stall freezes the whole pipeline only while the last stage holds a
// result; req_stall follows then. Reset clears valid bits and loads the
// matrix to identity. CSR writes are always ready.
module sphere_frustum_cull_test #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_sphere_x,
   input  wire logic [31:0] req_sphere_y,
   input  wire logic [31:0] req_sphere_z,
   input  wire logic [30:0] req_sphere_radius,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_visible,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   localparam int NW = sfct_pkg::NORM_W;
   localparam int DEPTH = 6;

   // configuration registers
   logic [63:0] vp_ff [sfct_pkg::NUM_REGS];
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff[sfct_pkg::REG_E01]   <= 64'd65536;
         vp_ff[sfct_pkg::REG_E23]   <= '0;
         vp_ff[sfct_pkg::REG_E45]   <= 64'd65536 << 32;
         vp_ff[sfct_pkg::REG_E67]   <= '0;
         vp_ff[sfct_pkg::REG_E89]   <= '0;
         vp_ff[sfct_pkg::REG_E1011] <= 64'd65536;
         vp_ff[sfct_pkg::REG_E1213] <= '0;
         vp_ff[sfct_pkg::REG_E1415] <= 64'd65536 << 32;
      end else if (csr_valid && csr_ready) begin
         vp_ff[csr_index] <= csr_wdata;
      end
   end

   logic signed [sfct_pkg::ELEM_W-1:0] m [16];
   always_comb begin
      for (int i = 0; i < 16; i++) m[i] = vp_ff[i/2][(i%2)*32 +: 32];
   end

   // pipeline control: advance unless a held result is stalled
   logic [DEPTH-1:0] vld_ff;
   logic en;
   assign en = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
   end

   // stage 0: register planes and sphere
   logic signed [NW-1:0] n_ff [6][3];
   logic signed [NW-1:0] d_ff [6];
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0] r_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 6; k++) begin
            for (int c = 0; c < 3; c++) begin
               n_ff[k][c] <= (k % 2 == 0) ? NW'(m[4*c+3]) + NW'(m[4*c+k/2])
                                          : NW'(m[4*c+3]) - NW'(m[4*c+k/2]);
            end
            d_ff[k] <= (k % 2 == 0) ? NW'(m[15]) + NW'(m[12+k/2])
                                    : NW'(m[15]) - NW'(m[12+k/2]);
         end
         cx_ff <= req_sphere_x;
         cy_ff <= req_sphere_y;
         cz_ff <= req_sphere_z;
         r_ff  <= req_sphere_radius;
      end
   end

   logic [5:0] pass;
   for (genvar k = 0; k < 6; k++) begin : g_plane
      sfct_plane #(.FRAC_BITS(FRAC_BITS)) u_plane (
         .clock(clock), .en(en),
         .n0(n_ff[k][0]), .n1(n_ff[k][1]), .n2(n_ff[k][2]), .dofs(d_ff[k]),
         .cx(cx_ff), .cy(cy_ff), .cz(cz_ff), .rad(r_ff), .pass(pass[k])
      );
   end

   assign rsp_valid   = vld_ff[DEPTH-1];
   assign rsp_visible = &pass;

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_visible))
      else $error("held result changed");
   // no input taken while output is stalled
   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pipeline advanced under stall");
   // an accepted request reaches rsp_valid when rsp_stall stays low behind it
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result lost");
endmodule
`default_nettype wire

[tb/sv/sphere_frustum_cull_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_frustum_cull_test_tb: self-checking bench for the frustum cull test
// Streams bounding spheres through the block under several matrices. An
// exact wide-integer predictor gives the visible flag for every accepted
// sphere. Results are compared in order, with random idling on both sides.
// ----------------------------------------------------------------------------

class cull_scoreboard;
   localparam int FRAC_W = 16;

   logic [63:0] vp_regs [sfct_pkg::NUM_REGS];
   bit          pending_vis [$];
   int          mismatches;
   int          unexpected;

   function void reset_matrix();
      foreach (vp_regs[i]) vp_regs[i] = 64'd0;
      vp_regs[sfct_pkg::REG_E01]   = 64'd65536;
      vp_regs[sfct_pkg::REG_E45]   = 64'd65536 << 32;
      vp_regs[sfct_pkg::REG_E1011] = 64'd65536;
      vp_regs[sfct_pkg::REG_E1415] = 64'd65536 << 32;
      mismatches = 0;
      unexpected = 0;
   endfunction

   function logic signed [31:0] element(int i);
      logic [63:0] r;
      r = vp_regs[i >> 1];
      return (i & 1) ? r[63:32] : r[31:0];
   endfunction

   // exact plane test; the square root is avoided by squaring both sides
   function bit plane_passes(int k, logic signed [31:0] cx, logic signed [31:0] cy,
                             logic signed [31:0] cz, logic [30:0] radius);
      logic signed [32:0] n0, n1, n2, d;
      logic signed [79:0] sdist;
      logic [79:0]        len2;
      logic [159:0]       dd, rw, lw, lhs, rhs;
      int                 a;
      bit                 neg;
      a   = k >> 1;
      neg = 1'(k & 1);
      n0 = neg ? element(3) - element(a)      : element(3) + element(a);
      n1 = neg ? element(7) - element(4 + a)  : element(7) + element(4 + a);
      n2 = neg ? element(11) - element(8 + a) : element(11) + element(8 + a);
      d  = neg ? element(15) - element(12 + a) : element(15) + element(12 + a);
      len2 = n0 * n0 + n1 * n1 + n2 * n2;
      // degenerate plane always passes
      if (len2 == 0) return 1'b1;
      sdist = n0 * cx + n1 * cy + n2 * cz + (d <<< FRAC_W);
      if (sdist >= 0) return 1'b1;
      dd  = {80'd0, 80'(-sdist)};
      rw  = {129'd0, radius};
      lw  = {80'd0, len2};
      lhs = dd * dd;
      rhs = rw * rw * lw;
      return lhs <= rhs;
   endfunction

   function void note_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [30:0] r);
      bit vis;
      vis = 1'b1;
      for (int k = 0; k < sfct_pkg::NUM_PLANES; k++)
         if (!plane_passes(k, x, y, z, r)) vis = 1'b0;
      pending_vis.push_back(vis);
   endfunction

   function void check_visible(logic actual);
      bit want;
      if (pending_vis.size() == 0) begin
         unexpected++;
         if (mismatches + unexpected <= 10)
            $display("unexpected result transaction: visible=%b", actual);
         return;
      end
      want = pending_vis.pop_front();
      if (actual !== want) begin
         mismatches++;
         if (mismatches + unexpected <= 10)
            $display("visible mismatch: expected %b, actual %b", want, actual);
      end
   endfunction
endclass

module sphere_frustum_cull_test_tb;
   localparam sfct_pkg::reg_idx_type REG_LIST [sfct_pkg::NUM_REGS] = '{
      sfct_pkg::REG_E01, sfct_pkg::REG_E23, sfct_pkg::REG_E45, sfct_pkg::REG_E67,
      sfct_pkg::REG_E89, sfct_pkg::REG_E1011, sfct_pkg::REG_E1213,
      sfct_pkg::REG_E1415};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sphere_x = '0;
   logic [31:0] req_sphere_y = '0;
   logic [31:0] req_sphere_z = '0;
   logic [30:0] req_sphere_radius = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_visible;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   sfct_pkg::reg_idx_type csr_index = sfct_pkg::REG_E01;
   logic [63:0] csr_wdata = '0;

   cull_scoreboard board = new();
   int send_idle_pct = 13;
   int recv_idle_pct = 47;
   int long_hold = 0;
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;

   sphere_frustum_cull_test DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sphere_x(req_sphere_x), .req_sphere_y(req_sphere_y),
      .req_sphere_z(req_sphere_z), .req_sphere_radius(req_sphere_radius),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_visible(rsp_visible),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // check accepted results and drive the receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_visible(rsp_visible);
      if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
         long_hold <= 300;
      end else if (long_hold > 0) begin
         rsp_stall <= 1'b1;
         long_hold <= long_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("sphere_frustum_cull_test test failed");
      $finish;
   end

   task automatic send_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [30:0] r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sphere_x      <= x;
      req_sphere_y      <= y;
      req_sphere_z      <= z;
      req_sphere_radius <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sphere(x, y, z, r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_vis.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(sfct_pkg::reg_idx_type idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.vp_regs[idx] = data;
   endtask

   // small fixed-point value within +-range units of one
   function automatic logic [31:0] small_q(int range);
      return 32'($signed($urandom_range(2 * range * 65536)) - range * 65536);
   endfunction

   task automatic load_matrix(int kind);
      logic [63:0] v;
      for (int j = 0; j < sfct_pkg::NUM_REGS; j++) begin
         case (kind)
            0: v = board.vp_regs[REG_LIST[j]];
            1: v = 64'd0;
            2: v = {64{1'b1}};
            3: v = {2{32'h7FFF_FFFF}};
            4: v = {2{32'h8000_0000}};
            5: v = {$urandom, $urandom};
            default: v = {small_q(2), small_q(2)};
         endcase
         write_reg(REG_LIST[j], v);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_sphere();
      if ($urandom_range(3) == 0)
         send_sphere($urandom, $urandom, $urandom, 31'($urandom));
      else
         send_sphere(small_q(4), small_q(4), small_q(4), 31'($urandom_range(3 * 65536)));
   endtask

   initial begin
      board.reset_matrix();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed spheres against the reset matrix
      send_sphere(0, 0, 0, 0);
      send_sphere(32'h0001_0000, 0, 0, 0);          // point on a plane
      send_sphere(32'h0001_0001, 0, 0, 0);          // just outside
      send_sphere(32'h0002_0000, 0, 0, 31'h0001_0000); // touching
      send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_sphere(32'h8000_0000, 0, 0, 31'h7FFF_FFFF);
      send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF);
      send_sphere(0, 32'hFFFF_0000, 32'h0000_8000, 31'h0000_4000);
      send_sphere(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1);
      drain();

      // degenerate planes: every sphere visible
      load_matrix(1);
      send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 0);
      send_sphere(0, 0, 0, 31'h7FFF_FFFF);
      drain();

      // extreme matrices
      for (int kind = 2; kind <= 4; kind++) begin
         load_matrix(kind);
         send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
         send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
         send_sphere(0, 0, 0, 0);
         drain();
      end

      // random phases
      for (int p = 0; p < 8; p++) begin
         if (p < 3) begin
            send_idle_pct = 13; recv_idle_pct = 47;
         end else if (p < 6) begin
            send_idle_pct = 47; recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         load_matrix((p % 3 == 2) ? 5 : 6);
         for (int i = 0; i < 200; i++) begin
            // hold off the receiver so the pipeline backs up
            if (i == 50 && p == 1) hold_req = 1'b1;
            // pause until the block is empty
            if (i == 120 && p == 4) drain();
            random_sphere();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.unexpected == 0 && board.pending_vis.size() == 0)
         $display("sphere_frustum_cull_test test passed");
      else
         $display("sphere_frustum_cull_test test failed");
      $finish;
   end
endmodule
